/* src/gww_pkg.sv */
package gww_pkg;

  localparam int unsigned PosW   = 16;
  localparam int unsigned WidthW = 8;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  localparam logic [WidthW-1:0] LINE_WIDTH_RESET = 8'd80;
  localparam logic [WidthW-1:0] WIDTH_MAX        = 8'hFF;

  typedef struct packed {
    logic [PosW-1:0] line_start;
    logic            final_line;
  } result_t;

  // Up to two results per item: a break, then the end-of-text line start
  typedef struct packed {
    logic    brk_valid;
    logic    eot_valid;
    result_t brk_res;
    result_t eot_res;
  } res_pair_t;

endpackage

/* src/gww_core.sv */
module gww_core
  import gww_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [WidthW-1:0] cfg_wdata_i,
  input  logic              accept_i,
  input  logic [7:0]        ch_i,
  input  logic              eot_i,
  output res_pair_t         res_o
);

  logic [WidthW-1:0] line_width_q;
  logic [PosW-1:0]   pos_q, pos_d;
  logic [PosW-1:0]   cs_q, cs_d;
  logic [PosW-1:0]   sp_q, sp_d;
  logic [WidthW-1:0] rw_q, rw_d;
  logic              pcr_q, pcr_d;

  logic [WidthW-1:0] lw_eff;
  logic [PosW-1:0]   sp_eff;
  logic [PosW-1:0]   gap;
  logic [WidthW-1:0] rw_base;
  logic              carried;

  // Per-character line state update
  always_comb begin
    pos_d   = pos_q + 1'b1;
    cs_d    = cs_q;
    sp_d    = sp_q;
    rw_d    = rw_q;
    pcr_d   = 1'b0;
    res_o   = '0;
    lw_eff  = (line_width_q == '0) ? WidthW'(1) : line_width_q;
    sp_eff  = (ch_i == CH_SPACE) ? pos_q : sp_q;
    gap     = pos_q - sp_eff;
    rw_base = rw_q;
    carried = 1'b0;

    if (pcr_q && ch_i == CH_LF) begin
      // LF right after CR folds into the CR break
      cs_d = pos_q + 1'b1;
    end else begin
      sp_d = sp_eff;
      if (ch_i == CH_CR || ch_i == CH_LF) begin
        res_o.brk_valid = 1'b1;
        res_o.brk_res   = '{line_start: cs_q, final_line: 1'b0};
        cs_d  = pos_q + 1'b1;
        sp_d  = '0;
        rw_d  = '0;
        pcr_d = (ch_i == CH_CR);
      end else begin
        if (rw_q >= lw_eff) begin
          res_o.brk_valid = 1'b1;
          res_o.brk_res   = '{line_start: cs_q, final_line: 1'b0};
          if (sp_eff != '0) begin
            // Break after the last space, carry the word over
            cs_d    = sp_eff + 1'b1;
            rw_d    = (|gap[PosW-1:WidthW]) ? WIDTH_MAX : gap[WidthW-1:0];
            sp_d    = '0;
            carried = 1'b1;
          end else begin
            // No space on the line: break mid-word
            cs_d    = pos_q;
            rw_base = '0;
          end
        end
        if (!carried) begin
          rw_d = (rw_base != WIDTH_MAX) ? rw_base + 1'b1 : rw_base;
        end
      end
    end

    // Close the text and start over
    if (eot_i) begin
      res_o.eot_valid = 1'b1;
      res_o.eot_res   = '{line_start: cs_d, final_line: 1'b1};
      pos_d = '0;
      cs_d  = '0;
      sp_d  = '0;
      rw_d  = '0;
      pcr_d = 1'b0;
    end

    if (!accept_i) begin
      res_o.brk_valid = 1'b0;
      res_o.eot_valid = 1'b0;
    end
  end

  // Hold state between items, advance on accept
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_width_q <= LINE_WIDTH_RESET;
      pos_q        <= '0;
      cs_q         <= '0;
      sp_q         <= '0;
      rw_q         <= '0;
      pcr_q        <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        line_width_q <= cfg_wdata_i;
      end
      if (accept_i) begin
        pos_q <= pos_d;
        cs_q  <= cs_d;
        sp_q  <= sp_d;
        rw_q  <= rw_d;
        pcr_q <= pcr_d;
      end
    end
  end

endmodule

/* src/gww_out_fifo.sv */
module gww_out_fifo
  import gww_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  res_pair_t push_i,
  output logic      room_o,
  output logic      valid_o,
  input  logic      ready_i,
  output result_t   data_o
);

  result_t              mem_q [FifoDepth];
  logic [FifoPtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [FifoCntW-1:0]  cnt_q;
  logic                 pop;
  logic                 push_one, push_two;
  result_t              first, second;
  logic [FifoPtrW-1:0]  wr_ptr_nxt;

  assign pop      = valid_o && ready_i;
  assign push_two = push_i.brk_valid && push_i.eot_valid;
  assign push_one = push_i.brk_valid ^ push_i.eot_valid;
  assign first    = push_i.brk_valid ? push_i.brk_res : push_i.eot_res;
  assign second   = push_i.eot_res;
  assign wr_ptr_nxt = wr_ptr_q + 1'b1;

  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];
  // Keep room for the two results one item may cause
  assign room_o  = (cnt_q <= FifoCntW'(FifoDepth - 2));

  // Store results
  always_ff @(posedge clk_i) begin
    if (push_one || push_two) begin
      mem_q[wr_ptr_q] <= first;
    end
    if (push_two) begin
      mem_q[wr_ptr_nxt] <= second;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_two) begin
        wr_ptr_q <= wr_ptr_q + FifoPtrW'(2);
      end else if (push_one) begin
        wr_ptr_q <= wr_ptr_nxt;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      cnt_q <= cnt_q + FifoCntW'({push_two, push_one}) - FifoCntW'(pop);
    end
  end

endmodule

/* src/greedy_char_word_wrap.sv */
// Throughput: one character per cycle while the output queue has room for two results; a
//   character that both breaks a line and ends the text gives two results, which are stored
//   in the queue (four entries); it drains one result per cycle while m_axis_tready is high.
// Reset: rst_ni clears the line state and the output queue; line width returns to 80.
module greedy_char_word_wrap
  import gww_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [WidthW-1:0] cfg_wdata_i,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] ch
  input  logic              s_axis_tlast,   // end_of_text
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [PosW-1:0]   m_axis_tdata,   // [15:0] line_start
  output logic              m_axis_tlast    // final_line
);

  logic      accept;
  logic      room;
  res_pair_t res;
  result_t   out_res;

  assign s_axis_tready = room;
  assign accept        = s_axis_tvalid && room;

  gww_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .ch_i        (s_axis_tdata),
    .eot_i       (s_axis_tlast),
    .res_o       (res)
  );

  gww_out_fifo u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .data_o  (out_res)
  );

  assign m_axis_tdata = out_res.line_start;
  assign m_axis_tlast = out_res.final_line;

endmodule
